// ===== rtl/nmpc_pkg.sv =====
// shared types, constants and codes of the normal map pixel classifier
`timescale 1ns / 1ps

package nmpc_pkg;

	// sample bound and derived widths
	localparam int MAX_SAMPLES = 32768;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = $clog2(MAX_SAMPLES * 255 + 1);

	// pixel content thresholds
	localparam int BACKWARD_BLUE = 90;
	localparam int BLUE_MIN = 230;
	localparam int CENTER = 128;
	localparam int SPREAD = 60;
	localparam int RG_LOW = CENTER - SPREAD;
	localparam int RG_HIGH_EXCL = CENTER + SPREAD + 1;
	localparam int BACKWARD_SCALE = 100;

	// format class codes
	localparam logic [2:0] FMT_UNDECIDED = 3'd0;
	localparam logic [2:0] FMT_SRGB = 3'd1;
	localparam logic [2:0] FMT_BC5 = 3'd2;
	localparam logic [2:0] FMT_HDR = 3'd3;
	localparam logic [2:0] FMT_FEW_CHANNELS = 3'd4;
	localparam logic [2:0] FMT_ANALYZE = 3'd5;

	// usage codes
	localparam logic [2:0] USAGE_UNDECIDED = 3'd0;
	localparam logic [2:0] USAGE_COLOR = 3'd1;
	localparam logic [2:0] USAGE_NORMAL = 3'd2;
	localparam logic [2:0] USAGE_LINEAR = 3'd3;
	localparam logic [2:0] USAGE_HDR = 3'd4;

	// one finished image as handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0] red_sum;
		logic [SUM_W-1:0] green_sum;
		logic [SUM_W-1:0] blue_sum;
		logic [CNT_W-1:0] backward_count;
		logic [CNT_W-1:0] samples;
		logic [2:0]       format_class;
	} image_t;

	// handshake between two internal parts
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

// ===== rtl/nmpc_if.sv =====
// pixel and usage channel interfaces
`timescale 1ns / 1ps

interface nmpc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_pixel;

	modport source (output valid, red, green, blue, last_pixel, input ready);
	modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface nmpc_usage_if;
	logic       valid;
	logic       ready;
	logic [2:0] usage;

	modport source (output valid, usage, input ready);
	modport sink (input valid, usage, output ready);
endinterface

// ===== rtl/nmpc_front.sv =====
// front part: takes pixel items, accumulates sums and counts, emits finished images
`timescale 1ns / 1ps

module nmpc_front import nmpc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_wdata,
	nmpc_pix_if.sink      pix,
	output hs_t           push,
	input  logic          push_ready,
	output image_t        push_data
);

	logic [SUM_W-1:0] red_sum_q, green_sum_q, blue_sum_q;
	logic [CNT_W-1:0] backward_q, samples_q;
	logic [2:0]       format_q;
	logic             take;
	logic             room;
	logic             accept;
	image_t           next;

	// accumulate only below the sample bound
	assign room = samples_q < CNT_W'(MAX_SAMPLES);
	assign take = pix.valid && pix.ready;
	assign accept = take && room;

	always_comb begin
		next.red_sum = red_sum_q;
		next.green_sum = green_sum_q;
		next.blue_sum = blue_sum_q;
		next.backward_count = backward_q;
		next.samples = samples_q;
		next.format_class = format_q;
		if (room) begin
			next.red_sum = red_sum_q + SUM_W'(pix.red);
			next.green_sum = green_sum_q + SUM_W'(pix.green);
			next.blue_sum = blue_sum_q + SUM_W'(pix.blue);
			next.samples = samples_q + CNT_W'(1);
			if (pix.blue < 8'(BACKWARD_BLUE)) begin
				next.backward_count = backward_q + CNT_W'(1);
			end
		end
	end

	// stall only when a last item finds the queue full
	assign pix.ready = push_ready || !pix.last_pixel;
	assign push.valid = pix.valid && pix.last_pixel;
	assign push.ready = push_ready;
	assign push_data = next;

	// format class register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_ANALYZE;
		end else if (cfg_we) begin
			format_q <= cfg_wdata;
		end
	end

	// running image state, cleared after each last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_sum_q <= '0;
			green_sum_q <= '0;
			blue_sum_q <= '0;
			backward_q <= '0;
			samples_q <= '0;
		end else if (take && pix.last_pixel) begin
			red_sum_q <= '0;
			green_sum_q <= '0;
			blue_sum_q <= '0;
			backward_q <= '0;
			samples_q <= '0;
		end else if (accept) begin
			red_sum_q <= next.red_sum;
			green_sum_q <= next.green_sum;
			blue_sum_q <= next.blue_sum;
			backward_q <= next.backward_count;
			samples_q <= next.samples;
		end
	end

endmodule

// ===== rtl/nmpc_queue.sv =====
// two-entry queue of finished images between front and back
`timescale 1ns / 1ps

module nmpc_queue import nmpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  hs_t    push,
	input  image_t push_data,
	output logic   push_ready,
	output logic   pop_valid,
	input  logic   pop_ready,
	output image_t pop_data
);

	image_t     entry_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign pop_data = entry_q[rd_q];
	assign do_push = push.valid && push.ready;
	assign do_pop = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/nmpc_back.sv =====
// back part: classifies a finished image and holds the usage item for the sink
`timescale 1ns / 1ps

module nmpc_back import nmpc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  image_t        pop_data,
	nmpc_usage_if.source  res
);

	logic             out_valid_q;
	logic [2:0]       usage_q;
	logic [2:0]       usage_next;
	logic [2:0]       content;
	logic [SUM_W-1:0] n_w, blue_floor, rg_low, rg_high, bw_scaled;
	logic             color;

	// constant products stand in for the floor averages
	assign n_w = SUM_W'(pop_data.samples);
	assign blue_floor = n_w * SUM_W'(BLUE_MIN);
	assign rg_low = n_w * SUM_W'(RG_LOW);
	assign rg_high = n_w * SUM_W'(RG_HIGH_EXCL);
	assign bw_scaled = SUM_W'(pop_data.backward_count) * SUM_W'(BACKWARD_SCALE);

	assign color = (pop_data.blue_sum < blue_floor)
		|| (pop_data.red_sum < rg_low) || (pop_data.red_sum >= rg_high)
		|| (pop_data.green_sum < rg_low) || (pop_data.green_sum >= rg_high)
		|| (bw_scaled > n_w);

	assign content = (pop_data.samples == '0) ? USAGE_UNDECIDED :
		(color ? USAGE_COLOR : USAGE_NORMAL);

	// format class mapping
	always_comb begin
		case (pop_data.format_class)
			FMT_UNDECIDED: usage_next = USAGE_UNDECIDED;
			FMT_SRGB: usage_next = USAGE_COLOR;
			FMT_BC5: usage_next = USAGE_NORMAL;
			FMT_HDR: usage_next = USAGE_HDR;
			FMT_FEW_CHANNELS: usage_next = USAGE_LINEAR;
			FMT_ANALYZE: usage_next = content;
			default: usage_next = USAGE_UNDECIDED;
		endcase
	end

	assign pop_ready = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.usage = usage_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			usage_q <= usage_next;
		end
	end

endmodule

// ===== rtl/normal_map_pixel_classifier.sv =====
// top level of the normal map pixel classifier
`timescale 1ns / 1ps

// Takes one sampled pixel item per cycle and gives one usage item for each
// pixel marked last. The front accumulates channel sums and counts in registers;
// a last item copies the image into a two-entry queue and clears the sums,
// so the next image can start in the following cycle. The back classifies a
// queued image combinationally through constant products and holds the usage item
// in an output register, fed from the queue after the last pixel is taken. Input
// stalls only when a last item arrives while both queue entries are waiting.
// Pixels past the sample bound are counted out of the sums. format_class is
// written through cfg_we and cfg_wdata, resets to analyze and is sampled with
// each last pixel.

module normal_map_pixel_classifier import nmpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	nmpc_pix_if.sink     pix,
	nmpc_usage_if.source res
);

	hs_t    push;
	logic   push_ready;
	image_t push_data;
	logic   pop_valid, pop_ready;
	image_t pop_data;

	// accumulation front
	nmpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pix        (pix),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// image queue
	nmpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// classification back
	nmpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res       (res)
	);

endmodule

// ===== verif/normal_map_pixel_classifier_checker.sv =====
// checker that predicts and compares usage items of the normal map pixel classifier
`timescale 1ns / 1ps

module normal_map_pixel_classifier_checker import nmpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	nmpc_pix_if        pix,
	nmpc_usage_if      res,
	output int         failures,
	output int         pending,
	output int         results_seen
);

	// own copy of the format class and the running image state
	logic [2:0]       class_copy;
	logic [SUM_W-1:0] red_acc;
	logic [SUM_W-1:0] green_acc;
	logic [SUM_W-1:0] blue_acc;
	logic [CNT_W-1:0] backward_acc;
	logic [CNT_W-1:0] sample_acc;
	logic [2:0]       usage_due[$];

	// follow config writes and pixel items, compare usage items in order
	always @(posedge clk or negedge arst_n) begin
		logic [2:0] verdict;
		logic [2:0] due;
		longint     n;
		if (!arst_n) begin
			class_copy = FMT_ANALYZE;
			red_acc = '0;
			green_acc = '0;
			blue_acc = '0;
			backward_acc = '0;
			sample_acc = '0;
			usage_due.delete();
			failures = 0;
			results_seen = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				class_copy = cfg_wdata;

			// usage item leaving the block
			if (res.valid && res.ready) begin
				results_seen++;
				if (usage_due.size() == 0) begin
					failures++;
					$display("%0t ERROR usage item %0d arrived with none expected",
						$time, res.usage);
				end else begin
					due = usage_due.pop_front();
					if (res.usage !== due) begin
						failures++;
						$display("%0t ERROR usage expected %0d got %0d", $time, due, res.usage);
					end
				end
			end

			// pixel item entering the block
			if (pix.valid && pix.ready) begin
				// samples past the bound are dropped from the sums
				if (sample_acc < MAX_SAMPLES) begin
					red_acc = red_acc + pix.red;
					green_acc = green_acc + pix.green;
					blue_acc = blue_acc + pix.blue;
					if (pix.blue < BACKWARD_BLUE)
						backward_acc = backward_acc + 1'b1;
					sample_acc = sample_acc + 1'b1;
				end
				if (pix.last_pixel) begin
					n = sample_acc;
					case (class_copy)
						FMT_UNDECIDED:    verdict = USAGE_UNDECIDED;
						FMT_SRGB:         verdict = USAGE_COLOR;
						FMT_BC5:          verdict = USAGE_NORMAL;
						FMT_HDR:          verdict = USAGE_HDR;
						FMT_FEW_CHANNELS: verdict = USAGE_LINEAR;
						FMT_ANALYZE: begin
							// floor averages judged through products with the count, the backward share by division
							if (n == 0)
								verdict = USAGE_UNDECIDED;
							else if (blue_acc < BLUE_MIN * n)
								verdict = USAGE_COLOR;
							else if (red_acc < RG_LOW * n || red_acc >= RG_HIGH_EXCL * n)
								verdict = USAGE_COLOR;
							else if (green_acc < RG_LOW * n || green_acc >= RG_HIGH_EXCL * n)
								verdict = USAGE_COLOR;
							else if (backward_acc > n / BACKWARD_SCALE)
								verdict = USAGE_COLOR;
							else
								verdict = USAGE_NORMAL;
						end
						default:          verdict = USAGE_UNDECIDED;
					endcase
					usage_due.push_back(verdict);
					red_acc = '0;
					green_acc = '0;
					blue_acc = '0;
					backward_acc = '0;
					sample_acc = '0;
				end
			end
			pending <= usage_due.size();
		end
	end

endmodule

// ===== verif/normal_map_pixel_classifier_test.sv =====
// stimulus, clocking and verdict for the normal map pixel classifier
`timescale 1ns / 1ps

module normal_map_pixel_classifier_test;
	import nmpc_pkg::*;

	localparam int LIMIT = 500000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_PIXELS = 120;

	// format class values with no meaning of their own
	localparam logic [2:0] FMT_RESERVED_6 = 3'd6;
	localparam logic [2:0] FMT_RESERVED_7 = 3'd7;

	typedef enum int {IMG_NORMAL, IMG_BORDER, IMG_NOISE} image_kind_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	nmpc_pix_if   pix();
	nmpc_usage_if res();

	int failures;
	int pending;
	int results_seen;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen;
	int hold_left;
	int cycles = 0;
	int pixels_sent = 0;
	int images_sent = 0;

	normal_map_pixel_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix),
		.res       (res)
	);

	normal_map_pixel_classifier_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.pix          (pix),
		.res          (res),
		.failures     (failures),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("run stopped after %0d cycles with %0d usage items due", cycles, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// usage receiver: random stalls plus a long hold on request
	initial begin
		res.ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// offer one pixel item, with random idle cycles ahead of it
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.red <= r;
		pix.green <= g;
		pix.blue <= b;
		pix.last_pixel <= last;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		pixels_sent++;
	endtask

	// stop offering and wait until every usage item has come back
	task automatic wait_drained();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_class(input logic [2:0] cls);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= cls;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one image of the given length, content shaped by its kind
	task automatic send_image(input int len, input image_kind_t kind);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		int         back_pct;
		back_pct = $urandom_range(2);
		for (int i = 0; i < len; i++) begin
			case (kind)
				IMG_NORMAL: begin
					r = 8'($urandom_range(166, 90));
					g = 8'($urandom_range(166, 90));
					if ($urandom_range(99) < back_pct)
						b = 8'($urandom_range(89, 0));
					else
						b = 8'($urandom_range(255, 226));
				end
				IMG_BORDER: begin
					r = $urandom_range(1) ? 8'($urandom_range(75, 60)) : 8'($urandom_range(196, 181));
					g = $urandom_range(1) ? 8'($urandom_range(75, 60)) : 8'($urandom_range(196, 181));
					b = 8'($urandom_range(240, 222));
				end
				default: begin
					r = 8'($urandom_range(255));
					g = 8'($urandom_range(255));
					b = 8'($urandom_range(255));
				end
			endcase
			send_pixel(r, g, b, i == len - 1);
		end
		images_sent++;
	endtask

	// mixed image lengths and kinds, occasional class changes and full pauses
	task automatic random_phase(input int idle_pct, input int stall_pct);
		int          target;
		int          roll;
		int          len;
		image_kind_t kind;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = pixels_sent + PHASE_PIXELS;
		while (pixels_sent < target) begin
			roll = $urandom_range(99);
			if (roll < 8)
				write_class($urandom_range(99) < 60 ? FMT_ANALYZE : 3'($urandom_range(7)));
			else if (roll < 12)
				wait_drained();
			roll = $urandom_range(99);
			if (roll < 70)
				len = $urandom_range(16, 1);
			else if (roll < 95)
				len = $urandom_range(120, 17);
			else
				len = $urandom_range(300, 100);
			roll = $urandom_range(99);
			kind = roll < 60 ? IMG_NORMAL : (roll < 80 ? IMG_BORDER : IMG_NOISE);
			send_image(len, kind);
		end
		wait_drained();
	endtask

	// stimulus and verdict
	initial begin
		logic [2:0] class_walk[7];
		class_walk = '{FMT_UNDECIDED, FMT_SRGB, FMT_BC5, FMT_HDR, FMT_FEW_CHANNELS,
			FMT_RESERVED_6, FMT_RESERVED_7};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = FMT_ANALYZE;
		pix.valid = 1'b0;
		pix.red = '0;
		pix.green = '0;
		pix.blue = '0;
		pix.last_pixel = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// analysis from the reset class: thresholds on each side
		send_pixel(8'd128, 8'd128, 8'd255, 1'b1);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd68, 8'd188, 8'd230, 1'b1);
		send_pixel(8'd67, 8'd128, 8'd255, 1'b1);
		send_pixel(8'd128, 8'd189, 8'd255, 1'b1);
		send_pixel(8'd128, 8'd128, 8'd229, 1'b1);
		send_pixel(8'd128, 8'd128, 8'd255, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd89, 1'b1);

		// every class setting other than analyze settles the usage without looking at content
		foreach (class_walk[i]) begin
			write_class(class_walk[i]);
			send_pixel(8'd128, 8'd128, 8'd255, 1'b1);
		end
		write_class(FMT_ANALYZE);

		// long output hold while short images keep coming, so the input backs up
		hold_req++;
		repeat (16)
			send_image($urandom_range(3, 1), $urandom_range(1) ? IMG_NORMAL : IMG_NOISE);
		wait_drained();

		random_phase(0, 0);
		random_phase(63, 0);
		random_phase(0, 63);
		random_phase(20, 20);
		write_class(FMT_ANALYZE);
		random_phase(0, 0);

		wait_drained();
		$display("sent %0d pixels in %0d images, %0d usage items checked",
			pixels_sent, images_sent, results_seen);
		$display("covered all eight class values, threshold edges and a long output hold");
		if (failures == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d usage items never arrived", failures, pending);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
